// ===== rtl/tagged_byte_frame_parser_defines.svh =====
// assertion macros for the frame parser rtl
`ifndef TAGGED_BYTE_FRAME_PARSER_DEFINES_SVH
`define TAGGED_BYTE_FRAME_PARSER_DEFINES_SVH

// checked only while out of reset
`define TBFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define TBFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tbfp_pkg.sv =====
`timescale 1ns / 1ps
// types, register indexes and reset values of the tagged byte frame parser
package tbfp_pkg;

    localparam int unsigned MAX_FRAME_LEN_DEF = 16;

    localparam logic [7:0] HEAD_BYTE_RESET    = 8'hAA;
    localparam logic [7:0] POINT_TAG_RESET    = 8'h55;
    localparam logic [7:0] LINE_TAG_RESET     = 8'h66;
    localparam logic [7:0] TAIL_BYTE_RESET    = 8'hBB;
    localparam logic [4:0] MIN_LEN_RESET      = 5'd7;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned MIN_LEN_W = 5;
    localparam int unsigned PAYLOAD_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_BYTE     = 3'd0,
        CFG_POINT_TAG     = 3'd1,
        CFG_LINE_TAG      = 3'd2,
        CFG_TAIL_BYTE     = 3'd3,
        CFG_MIN_FRAME_LEN = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_TAG   = 2'd1,
        PH_POINT = 2'd2,
        PH_LINE  = 2'd3
    } phase_t;

    typedef logic [7:0] payload_t [PAYLOAD_DEPTH];

endpackage

// ===== rtl/tagged_byte_frame_parser.sv =====
`timescale 1ns / 1ps
// tagged byte frame parser: head, tag, payload, tail framing with a result register
// result: res_valid is set in the cycle after the tail beat of a frame that meets the minimum
// throughput: one rx byte per cycle; rx_ready drops only while a result waits and
// res_ready is low, since the single result register is the only thing that can fill
// reset: rst_n is asynchronous, active low; the hunt restarts, registers take their
// default values, no result is pending; payload bytes are undefined until written
`include "tagged_byte_frame_parser_defines.svh"

module tagged_byte_frame_parser #(
    parameter int unsigned MAX_FRAME_LEN = tbfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // byte stream in
    input  logic                            rx_valid,
    output logic                            rx_ready,
    input  logic [7:0]                      rx_byte,

    // decoded frame out
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            frame_kind,
    output logic signed [15:0]              first_value,
    output logic signed [15:0]              second_value,

    // register write port
    input  logic                            cfg_we,
    input  logic [tbfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbfp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // the count never exceeds the frame limit, so it only needs room for that
    localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);
    // compare width that holds both the count plus one and the 5-bit minimum
    localparam int unsigned CMP_W = ((CNT_W > tbfp_pkg::MIN_LEN_W) ? CNT_W
                                     : tbfp_pkg::MIN_LEN_W) + 1;
    localparam logic [CMP_W-1:0] MAX_LEN_CMP = CMP_W'(MAX_FRAME_LEN);

    // configuration registers
    logic [7:0]                       head_reg;
    logic [7:0]                       point_tag_reg;
    logic [7:0]                       line_tag_reg;
    logic [7:0]                       tail_reg;
    logic [tbfp_pkg::MIN_LEN_W-1:0]   min_len_reg;

    // parser state
    tbfp_pkg::phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    tbfp_pkg::payload_t               payload_reg, payload_next;

    // result register
    logic                             res_valid_reg, res_valid_next;
    logic                             kind_reg, kind_next;
    logic [15:0]                      first_reg, first_next;
    logic [15:0]                      second_reg, second_next;

    logic                             rx_take;
    logic                             res_take;
    logic [CMP_W-1:0]                 cnt_inc;
    logic                             in_slot;
    logic [1:0]                       slot_idx;
    logic                             is_head;
    logic                             is_point;
    logic                             is_line;
    logic                             is_tail;
    logic                             res_load;

    // a new byte may enter whenever the result register is empty or draining
    assign rx_ready = !res_valid_reg || res_ready;
    assign rx_take  = rx_valid && rx_ready;
    assign res_take = res_valid_reg && res_ready;

    assign is_head  = (rx_byte == head_reg);
    assign is_point = (rx_byte == point_tag_reg);
    assign is_line  = (rx_byte == line_tag_reg);
    assign is_tail  = (rx_byte == tail_reg);

    assign cnt_inc  = CMP_W'(cnt_reg) + CMP_W'(1);
    // frame bytes 2..5 land in the payload slots
    assign in_slot  = (CMP_W'(cnt_reg) >= CMP_W'(2)) && (CMP_W'(cnt_reg) <= CMP_W'(5));
    assign slot_idx = cnt_reg[1:0] - 2'd2;

    // register writes, out-of-range indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= tbfp_pkg::HEAD_BYTE_RESET;
            point_tag_reg <= tbfp_pkg::POINT_TAG_RESET;
            line_tag_reg  <= tbfp_pkg::LINE_TAG_RESET;
            tail_reg      <= tbfp_pkg::TAIL_BYTE_RESET;
            min_len_reg   <= tbfp_pkg::MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbfp_pkg::CFG_HEAD_BYTE:     head_reg      <= cfg_data[7:0];
                tbfp_pkg::CFG_POINT_TAG:     point_tag_reg <= cfg_data[7:0];
                tbfp_pkg::CFG_LINE_TAG:      line_tag_reg  <= cfg_data[7:0];
                tbfp_pkg::CFG_TAIL_BYTE:     tail_reg      <= cfg_data[7:0];
                tbfp_pkg::CFG_MIN_FRAME_LEN: min_len_reg   <= cfg_data[tbfp_pkg::MIN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // per-byte parse step
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        payload_next = payload_reg;
        res_load     = 1'b0;

        if (rx_take)
        begin
            unique case (phase_reg)
                tbfp_pkg::PH_HUNT:
                begin
                    // head byte opens a frame as byte zero
                    if (is_head)
                    begin
                        cnt_next   = CNT_W'(1);
                        phase_next = tbfp_pkg::PH_TAG;
                    end
                end
                tbfp_pkg::PH_TAG:
                begin
                    // tag match wins over a repeated head; equal tags mean line
                    if (is_point || is_line)
                    begin
                        phase_next = is_line ? tbfp_pkg::PH_LINE : tbfp_pkg::PH_POINT;
                        cnt_next   = cnt_inc[CNT_W-1:0];
                    end
                    else if (!is_head)
                    begin
                        phase_next = tbfp_pkg::PH_HUNT;
                        cnt_next   = '0;
                    end
                end
                tbfp_pkg::PH_POINT, tbfp_pkg::PH_LINE:
                begin
                    if (is_tail)
                    begin
                        // tail is stored too when it lands in a payload slot
                        if (in_slot)
                        begin
                            payload_next[slot_idx] = rx_byte;
                        end
                        res_load   = (cnt_inc >= CMP_W'(min_len_reg));
                        phase_next = tbfp_pkg::PH_HUNT;
                        cnt_next   = '0;
                    end
                    else if (cnt_inc >= MAX_LEN_CMP)
                    begin
                        // no room left for the tail, drop the frame
                        phase_next = tbfp_pkg::PH_HUNT;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        if (in_slot)
                        begin
                            payload_next[slot_idx] = rx_byte;
                        end
                        cnt_next = cnt_inc[CNT_W-1:0];
                    end
                end
                default:
                begin
                    phase_next = tbfp_pkg::PH_HUNT;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    // result register: load on an accepted frame, clear once taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        kind_next      = kind_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        if (res_take)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
            kind_next      = (phase_reg == tbfp_pkg::PH_LINE);
            first_next     = {payload_next[0], payload_next[1]};
            second_next    = {payload_next[2], payload_next[3]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tbfp_pkg::PH_HUNT;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload and result data carry no reset
    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        kind_reg    <= kind_next;
        first_reg   <= first_next;
        second_reg  <= second_next;
    end

    assign res_valid    = res_valid_reg;
    assign frame_kind   = kind_reg;
    assign first_value  = signed'(first_reg);
    assign second_value = signed'(second_reg);

    // count stays inside the frame limit
    `TBFP_ASSERT(a_cnt_bound, CMP_W'(cnt_reg) < MAX_LEN_CMP, "byte count past frame limit")
    // hunting holds no bytes, tag wait holds just the head
    `TBFP_ASSERT(a_cnt_phase, ((phase_reg != tbfp_pkg::PH_HUNT) || (cnt_reg == '0)) && ((phase_reg != tbfp_pkg::PH_TAG) || (cnt_reg == CNT_W'(1))), "count does not match phase")
    // a fresh result only follows a tail beat taken in a payload phase
    `TBFP_ASSERT(a_res_from_tail, $rose(res_valid_reg) |-> $past(rx_take && is_tail && ((phase_reg == tbfp_pkg::PH_POINT) || (phase_reg == tbfp_pkg::PH_LINE))), "result without tail beat")
    // no result pending just after reset is sampled
    `TBFP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !res_valid_reg, "result pending after reset")

endmodule

// ===== verif/tagged_byte_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// frame parser checker: tracks config writes, predicts decoded frames, compares results
module tagged_byte_frame_parser_checker #(
    parameter int unsigned MAX_FRAME_LEN = tbfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rx_valid,
    input  logic                            rx_ready,
    input  logic [7:0]                      rx_byte,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic                            frame_kind,
    input  logic signed [15:0]              first_value,
    input  logic signed [15:0]              second_value,
    input  logic                            cfg_we,
    input  logic [tbfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbfp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);

    typedef struct {
        logic               kind;
        logic signed [15:0] first;
        logic signed [15:0] second;
    } decoded_frame_t;

    // own copy of the register file
    logic [7:0]                     head_val;
    logic [7:0]                     point_val;
    logic [7:0]                     line_val;
    logic [7:0]                     tail_val;
    logic [tbfp_pkg::MIN_LEN_W-1:0] min_len;

    // own copy of the parser state
    tbfp_pkg::phase_t   rx_phase;
    logic [4:0]         frame_bytes;
    logic [7:0]         held [tbfp_pkg::PAYLOAD_DEPTH];

    decoded_frame_t     expected_frames [$];
    int                 mismatch_count = 0;

    // count one frame byte, keeping bytes 2..5
    task automatic keep_frame_byte(input logic [7:0] b);
        if (frame_bytes >= 5'd2 && frame_bytes <= 5'd5)
            held[frame_bytes - 5'd2] = b;
        frame_bytes = frame_bytes + 5'd1;
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        decoded_frame_t f;
        logic           ok;
        case (rx_phase)
            tbfp_pkg::PH_HUNT:
            begin
                if (b == head_val)
                begin
                    frame_bytes = 5'd0;
                    keep_frame_byte(b);
                    rx_phase = tbfp_pkg::PH_TAG;
                end
            end
            tbfp_pkg::PH_TAG:
            begin
                // tag meaning beats repeated head; equal tags make a line frame
                if (b == point_val || b == line_val)
                begin
                    rx_phase = (b == line_val) ? tbfp_pkg::PH_LINE : tbfp_pkg::PH_POINT;
                    keep_frame_byte(b);
                end
                else if (b != head_val)
                begin
                    rx_phase = tbfp_pkg::PH_HUNT;
                    frame_bytes = 5'd0;
                end
            end
            default:
            begin
                if (b == tail_val)
                begin
                    keep_frame_byte(b);
                    ok = (frame_bytes >= min_len);
                    f.kind = (rx_phase == tbfp_pkg::PH_LINE);
                    f.first = {held[0], held[1]};
                    f.second = {held[2], held[3]};
                    rx_phase = tbfp_pkg::PH_HUNT;
                    frame_bytes = 5'd0;
                    if (ok)
                        expected_frames.push_back(f);
                end
                else if (int'(frame_bytes) + 1 >= int'(MAX_FRAME_LEN))
                begin
                    // no room left for the tail
                    rx_phase = tbfp_pkg::PH_HUNT;
                    frame_bytes = 5'd0;
                end
                else
                begin
                    keep_frame_byte(b);
                end
            end
        endcase
    endtask

    task automatic compare_result();
        decoded_frame_t f;
        if (expected_frames.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual kind %0d first %0d second %0d",
                     $time, frame_kind, first_value, second_value);
            mismatch_count++;
        end
        else
        begin
            f = expected_frames.pop_front();
            if (frame_kind !== f.kind)
            begin
                $display("%0t: frame_kind expected %0d actual %0d", $time, f.kind, frame_kind);
                mismatch_count++;
            end
            if (first_value !== f.first)
            begin
                $display("%0t: first_value expected %0d actual %0d",
                         $time, f.first, first_value);
                mismatch_count++;
            end
            if (second_value !== f.second)
            begin
                $display("%0t: second_value expected %0d actual %0d",
                         $time, f.second, second_value);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_val <= tbfp_pkg::HEAD_BYTE_RESET;
            point_val <= tbfp_pkg::POINT_TAG_RESET;
            line_val <= tbfp_pkg::LINE_TAG_RESET;
            tail_val <= tbfp_pkg::TAIL_BYTE_RESET;
            min_len <= tbfp_pkg::MIN_LEN_RESET;
            rx_phase = tbfp_pkg::PH_HUNT;
            frame_bytes = 5'd0;
            expected_frames.delete();
            pending <= 0;
            errors <= mismatch_count;
        end
        else
        begin
            if (res_valid && res_ready)
                compare_result();
            if (rx_valid && rx_ready)
                decode_rx_byte(rx_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    tbfp_pkg::CFG_HEAD_BYTE:     head_val <= cfg_data;
                    tbfp_pkg::CFG_POINT_TAG:     point_val <= cfg_data;
                    tbfp_pkg::CFG_LINE_TAG:      line_val <= cfg_data;
                    tbfp_pkg::CFG_TAIL_BYTE:     tail_val <= cfg_data;
                    tbfp_pkg::CFG_MIN_FRAME_LEN: min_len <= cfg_data[tbfp_pkg::MIN_LEN_W-1:0];
                    default:                     ;
                endcase
            end
            pending <= expected_frames.size();
            errors <= mismatch_count;
        end
    end

endmodule

// ===== verif/tb_tagged_byte_frame_parser.sv =====
`timescale 1ns / 1ps
// frame parser testbench top: clock, reset, byte and register stimulus, verdict
module tb_tagged_byte_frame_parser;

    localparam int unsigned FRAME_MAX = tbfp_pkg::MAX_FRAME_LEN_DEF;
    // cycles without any beat before the run is declared hung
    localparam int          STALL_LIMIT = 2000;
    // random byte beats per traffic phase, seven phases
    localparam int          BEATS_PER_PHASE = 85;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            rx_valid = 1'b0;
    logic                            rx_ready;
    logic [7:0]                      rx_byte = 8'h00;
    logic                            res_valid;
    logic                            res_ready = 1'b0;
    logic                            frame_kind;
    logic signed [15:0]              first_value;
    logic signed [15:0]              second_value;
    logic                            cfg_we = 1'b0;
    logic [tbfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tbfp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int                    errors;
    int                    pending;

    // register values in force, used to shape the traffic
    logic [7:0]            cur_head = tbfp_pkg::HEAD_BYTE_RESET;
    logic [7:0]            cur_point = tbfp_pkg::POINT_TAG_RESET;
    logic [7:0]            cur_line = tbfp_pkg::LINE_TAG_RESET;
    logic [7:0]            cur_tail = tbfp_pkg::TAIL_BYTE_RESET;

    // calm phases run with no idling on either side
    bit                    calm = 1'b0;
    int                    beats_sent = 0;
    int                    stall_left = 0;
    int                    quiet_cycles = 0;

    always #10 clk = ~clk;

    tagged_byte_frame_parser #(
        .MAX_FRAME_LEN (FRAME_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .frame_kind   (frame_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tagged_byte_frame_parser_checker #(
        .MAX_FRAME_LEN (FRAME_MAX)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .frame_kind   (frame_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    // result side back-pressure: random stall bursts on res_ready
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = int'($urandom_range(0, 2));
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    // hang detection: any accepted beat on either channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && rx_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one byte beat; entered and left at a rising edge, valid stays up between
    // back-to-back beats so it never gets two updates in one step
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        beats_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq [$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // stop sending until every predicted frame is out, then let the parser settle
    task automatic wait_drained();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // writes all five registers back to back, with rx_valid low
    task automatic write_config(input logic [7:0] head, input logic [7:0] point,
                                input logic [7:0] line, input logic [7:0] tail,
                                input logic [tbfp_pkg::MIN_LEN_W-1:0] min_len);
        tbfp_pkg::cfg_index_t            idx [5];
        logic [tbfp_pkg::CFG_DATA_W-1:0] val [5];
        idx[0] = tbfp_pkg::CFG_HEAD_BYTE;
        idx[1] = tbfp_pkg::CFG_POINT_TAG;
        idx[2] = tbfp_pkg::CFG_LINE_TAG;
        idx[3] = tbfp_pkg::CFG_TAIL_BYTE;
        idx[4] = tbfp_pkg::CFG_MIN_FRAME_LEN;
        val[0] = head;
        val[1] = point;
        val[2] = line;
        val[3] = tail;
        val[4] = tbfp_pkg::CFG_DATA_W'(min_len);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_head = head;
        cur_point = point;
        cur_line = line;
        cur_tail = tail;
    endtask

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic run_traffic(input int beats);
        int         stop_at;
        int         pick;
        int         plen;
        bit         clean;
        logic [7:0] b;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_byte(cur_head);
                // repeated head while the tag is awaited
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) send_byte(cur_head);
                send_byte($urandom_range(0, 1) ? cur_point : cur_line);
                // now and then a frame that outgrows the frame limit
                if ($urandom_range(0, 9) == 0)
                    plen = $urandom_range(FRAME_MAX - 2, FRAME_MAX);
                else
                    plen = $urandom_range(0, FRAME_MAX - 3);
                // unclean payloads may carry the tail early
                clean = ($urandom_range(0, 4) != 0);
                for (int i = 0; i < plen; i++)
                begin
                    b = 8'($urandom);
                    while (clean && b == cur_tail)
                        b = 8'($urandom);
                    send_byte(b);
                end
                send_byte(cur_tail);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
            else
            begin
                send_byte(cur_head);
                if ($urandom_range(0, 1))
                begin
                    // likely a wrong tag
                    send_byte(8'($urandom));
                end
                else
                begin
                    // frame cut off before its tail
                    send_byte(cur_point);
                    repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        logic [7:0] h;
        logic [7:0] pt;
        logic [7:0] lt;
        logic [7:0] tl;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values; the first frame fills all four payload slots
        // so a short minimum never reads a slot that was never written
        send_bytes('{tbfp_pkg::HEAD_BYTE_RESET, tbfp_pkg::POINT_TAG_RESET, 8'h80, 8'h00,
                     8'h7F, 8'hFF, tbfp_pkg::TAIL_BYTE_RESET});
        // line frame behind a repeated head
        send_bytes('{tbfp_pkg::HEAD_BYTE_RESET, tbfp_pkg::HEAD_BYTE_RESET,
                     tbfp_pkg::LINE_TAG_RESET, 8'hFF, 8'hFF, 8'h00, 8'h00,
                     tbfp_pkg::TAIL_BYTE_RESET});
        // wrong tag, then frames that end early on the tail and are too short
        send_bytes('{tbfp_pkg::HEAD_BYTE_RESET, 8'h12});
        send_bytes('{tbfp_pkg::HEAD_BYTE_RESET, tbfp_pkg::POINT_TAG_RESET,
                     tbfp_pkg::TAIL_BYTE_RESET});
        send_bytes('{tbfp_pkg::HEAD_BYTE_RESET, tbfp_pkg::LINE_TAG_RESET, 8'h12,
                     tbfp_pkg::TAIL_BYTE_RESET});
        run_traffic(BEATS_PER_PHASE / 2);

        for (int phase = 1; phase <= 7; phase++)
        begin
            wait_drained();
            calm = (phase == 7) || ($urandom_range(0, 3) == 0);
            h = 8'($urandom);
            // tag equal to head, equal tags and tail equal to head now and then
            pt = ($urandom_range(0, 3) == 0) ? h : 8'($urandom);
            lt = ($urandom_range(0, 3) == 0) ? pt : 8'($urandom);
            tl = ($urandom_range(0, 5) == 0) ? h : 8'($urandom);
            case (phase)
                1: write_config(8'h00, 8'hFF, 8'h01, 8'hFE, 5'd2);
                2: write_config(8'hFF, 8'h00, 8'h00, 8'h80, 5'd16);
                3: write_config(h, pt, lt, tl, 5'($urandom_range(2, 5)));
                default: write_config(h, pt, lt, tl, 5'($urandom_range(2, 16)));
            endcase
            run_traffic(BEATS_PER_PHASE);
        end

        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tbfp_pkg.sv
rtl/tagged_byte_frame_parser.sv
verif/tagged_byte_frame_parser_checker.sv
verif/tb_tagged_byte_frame_parser.sv
